// File: rtl/rtpm_pkg.sv
// ----------------------------------------------------------------------------
// rtpm_pkg
// Shared types and codes of the route table: entry layout, the item token
// that walks the cell chain, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpm_pkg;

  localparam int ADDR_W   = 32;
  localparam int METRIC_W = 8;
  localparam int FLAGS_W  = 3;
  localparam int IFACE_W  = 4;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;

  localparam int IN_DATA_W  = 144;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 56;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOROUTE = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   net;
    logic [ADDR_W-1:0]   mask;
    logic [ADDR_W-1:0]   gw;
    logic [METRIC_W-1:0] metric;
    logic [FLAGS_W-1:0]  flags;
    logic [IFACE_W-1:0]  iface;
  } entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   gw;
    logic [METRIC_W-1:0] metric;
    logic [FLAGS_W-1:0]  flags;
    logic [IFACE_W-1:0]  iface;
    logic [SLOT_W-1:0]   slot;
  } result_t;

  // carry.net holds the destination address on a lookup
  typedef struct packed {
    logic              active;
    cmd_t              cmd;
    logic              full;
    logic              done;
    logic              carry_valid;
    logic [SLOT_W-1:0] pos;
    entry_t            carry;
    result_t           res;
  } token_t;

endpackage

`default_nettype wire

// File: rtl/rtpm_cell.sv
// ----------------------------------------------------------------------------
// rtpm_cell
// One table slot: holds an entry, matches a passing lookup, or takes a
// passing insert and hands the displaced entry to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpm_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  rtpm_pkg::token_t     tok_in,
  output rtpm_pkg::token_t     tok_out
);
  import rtpm_pkg::*;

  logic   valid;
  logic   valid_next;
  entry_t ent;
  entry_t ent_next;
  token_t tok_next;
  logic   hit;
  logic   take;

  always_comb begin
    tok_next   = tok_in;
    valid_next = valid;
    ent_next   = ent;
    hit  = valid && ((ent.mask & tok_in.carry.net) == (ent.mask & ent.net));
    take = tok_in.carry_valid &&
           (!valid || tok_in.done || (tok_in.carry.mask >= ent.mask));
    if (tok_in.active) begin
      if (tok_in.cmd == CMD_LOOKUP) begin
        if (!tok_in.done && hit) begin
          tok_next.done       = 1'b1;
          tok_next.res.gw     = ent.gw;
          tok_next.res.metric = ent.metric;
          tok_next.res.flags  = ent.flags;
          tok_next.res.iface  = ent.iface;
          tok_next.res.slot   = tok_in.pos;
        end
      end else if (take) begin
        valid_next           = 1'b1;
        ent_next             = tok_in.carry;
        tok_next.carry       = ent;
        tok_next.carry_valid = valid;
        if (!tok_in.done) begin
          tok_next.done     = 1'b1;
          tok_next.res.slot = tok_in.pos;
        end
      end
    end
    tok_next.pos = tok_in.pos + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      tok_out.active <= 1'b0;
    end else if (en) begin
      valid   <= valid_next;
      ent     <= ent_next;
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/route_table_prefix_match.sv
// ----------------------------------------------------------------------------
// route_table_prefix_match
// IPv4 route table with insert in descending mask order and longest-prefix
// lookup, built as a chain of one cell per table slot.
// ----------------------------------------------------------------------------
// Each item walks the chain of TABLE_DEPTH cells, one cell per cycle while the
// chain is not held, with one item in the table at a time: an item is accepted
// into the input token register, passes through the register of each cell in
// turn, and its result is then loaded into the output register; the next item
// can be accepted in the cycle after that load. The result register frees the
// input side while a result waits; the chain holds only when a finished item
// reaches its end and the previous result has not been taken. An insert into
// a full table is answered with status 2 and no change to the table.
`default_nettype none

module route_table_prefix_match #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // net_addr, netmask, gateway, route_metric, route_flags, iface, dest_addr
  input  wire logic [rtpm_pkg::IN_DATA_W-1:0]      s_tdata,
  // cmd
  input  wire logic [rtpm_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // out_gateway, out_metric, out_flags, out_iface, entry_slot
  output logic [rtpm_pkg::OUT_DATA_W-1:0]          m_tdata,
  // status
  output logic [rtpm_pkg::STATUS_W-1:0]            m_tuser
);
  import rtpm_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  token_t             tok [TABLE_DEPTH+1];
  token_t             tok_new;
  token_t             tok_end;
  logic [CNT_W-1:0]   entry_count;
  logic               busy;
  logic               accept;
  logic               advance;
  logic               is_full;
  cmd_t               cmd;
  status_t            status;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign cmd      = cmd_t'(s_tuser[0]);
  assign is_full  = (entry_count == CNT_W'(TABLE_DEPTH));
  assign tok_end  = tok[TABLE_DEPTH];
  assign advance  = !(tok_end.active && m_tvalid && !m_tready);

  always_comb begin
    tok_new             = '0;
    tok_new.active      = 1'b1;
    tok_new.cmd         = cmd;
    tok_new.full        = (cmd == CMD_INSERT) && is_full;
    tok_new.carry_valid = (cmd == CMD_INSERT) && !is_full;
    tok_new.carry.net   = (cmd == CMD_LOOKUP) ? s_tdata[142:111] : s_tdata[31:0];
    tok_new.carry.mask  = s_tdata[63:32];
    tok_new.carry.gw    = s_tdata[95:64];
    tok_new.carry.metric = s_tdata[103:96];
    tok_new.carry.flags = s_tdata[106:104];
    tok_new.carry.iface = s_tdata[110:107];
    if ((cmd == CMD_INSERT) && !is_full) begin
      tok_new.res.gw     = s_tdata[95:64];
      tok_new.res.metric = s_tdata[103:96];
      tok_new.res.flags  = s_tdata[106:104];
      tok_new.res.iface  = s_tdata[110:107];
    end
  end

  always_comb begin
    if (tok_end.full) begin
      status = ST_FULL;
    end else if ((tok_end.cmd == CMD_LOOKUP) && !tok_end.done) begin
      status = ST_NOROUTE;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].active <= 1'b0;
    end else if (accept) begin
      tok[0] <= tok_new;
    end else if (advance) begin
      tok[0].active <= 1'b0;
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    rtpm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (advance),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (accept && (cmd == CMD_INSERT) && !is_full) begin
      entry_count <= entry_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (advance && tok_end.active) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && tok_end.active) begin
      m_tvalid <= 1'b1;
      m_tuser  <= status;
      m_tdata  <= {5'd0, tok_end.res.slot, tok_end.res.iface, tok_end.res.flags,
                   tok_end.res.metric, tok_end.res.gw};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rtpm_checker.sv
// ----------------------------------------------------------------------------
// rtpm_checker
// Port-level checks of the route table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpm_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_tvalid,
  input wire logic                               s_tready,
  input wire logic [rtpm_pkg::IN_DATA_W-1:0]     s_tdata,
  input wire logic [rtpm_pkg::IN_USER_W-1:0]     s_tuser,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [rtpm_pkg::OUT_DATA_W-1:0]    m_tdata,
  input wire logic [rtpm_pkg::STATUS_W-1:0]      m_tuser
);
  import rtpm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in the table");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_NOROUTE) || (m_tuser == ST_FULL))
    else $error("undefined status");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == ST_NOROUTE) || (m_tuser == ST_FULL)) |-> (m_tdata == '0))
    else $error("no-route or full result carries data");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("pending item changed before it was taken");

endmodule

bind route_table_prefix_match rtpm_checker u_rtpm_checker (.*);

`default_nettype wire
